/* hdl/framed_link_receiver_defines.svh */
// -----------------------------------------------------------------------------
// Framed link receiver assertion macros
// Shared concurrent check forms for the receiver; clocked on clk, off in reset.
// -----------------------------------------------------------------------------
`ifndef FRAMED_LINK_RECEIVER_DEFINES_SVH
`define FRAMED_LINK_RECEIVER_DEFINES_SVH

// Same-cycle implication.
`define FLR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FLR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/flr_pkg.sv */
// -----------------------------------------------------------------------------
// Framed link receiver package
// Shared types, codes and the byte-wide CRC-32 step.
// -----------------------------------------------------------------------------
package flr_pkg;

	localparam int unsigned HeaderBytes = 5;
	localparam int unsigned CrcBytes    = 4;

	localparam logic [31:0] CrcPoly  = 32'hEDB8_8320;
	localparam logic [31:0] CrcInit  = 32'hFFFF_FFFF;
	localparam logic [15:0] MaxPayloadReset = 16'd1024;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_PREAMBLE = 2'd0,
		REG_ESCAPE   = 2'd1,
		REG_MAX_LEN  = 2'd2
	} reg_index_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_CRC_GOOD = 2'd1,
		KIND_CRC_BAD  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [31:0] preamble_word;
		logic [7:0]  escape_byte;
		logic [15:0] max_payload;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [15:0] frame_flags;
		logic [15:0] frame_length;
	} result_t;

	typedef struct packed {
		logic hunting;
	} status_t;

	// One reflected CRC-32 update over a byte, LSB first.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

/* hdl/framed_link_receiver.sv */
// -----------------------------------------------------------------------------
// Framed link receiver
// Byte-stuffed frame receiver: preamble hunt, checked header, streamed
// payload and a CRC-32 trailer verdict.
// -----------------------------------------------------------------------------
//  channel   | handshake                   | payload
//  ----------+-----------------------------+-----------------------------------
//  rx        | rx_valid / rx_ready         | rx_byte
//  result    | result_valid / result_ready | result_kind, payload_byte,
//            |                             | frame_flags, frame_length
//  config    | cfg_we (no wait)            | cfg_index, cfg_data
//
//  One word per cycle sustained while no result stall holds it; an accepted word passes
//  the input register, then the frame core into the result register.
//  The byte-wide CRC-32 step and the mode decode sit in the single stage between.
//  Reset clears the mode to hunting, the sync window and the registers to their
//  defaults; no clearing pass is needed.
//  A stalled result holds in its register; words that give no result keep
//  flowing past it, a word that gives one waits in the input register.
// -----------------------------------------------------------------------------
`include "framed_link_receiver_defines.svh"

module framed_link_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// received words
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	// results
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  result_kind,
	output logic [7:0]  payload_byte,
	output logic [15:0] frame_flags,
	output logic [15:0] frame_length,
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import flr_pkg::*;

	cfg_t    cfg_q;
	result_t res;
	status_t status;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_free;
	logic        advance;
	logic        load_out;
	logic        frame_end;

	logic        valid_s2;
	kind_t       kind_s2;
	logic [7:0]  payload_s2;
	logic [15:0] flags_s2;
	logic [15:0] length_s2;

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.preamble_word <= 32'd0;
			cfg_q.escape_byte   <= 8'd0;
			cfg_q.max_payload   <= MaxPayloadReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PREAMBLE: cfg_q.preamble_word <= cfg_data;
				REG_ESCAPE:   cfg_q.escape_byte   <= cfg_data[7:0];
				REG_MAX_LEN:  cfg_q.max_payload   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// The result register is free when empty or being drained this cycle.
	assign out_free = !valid_s2 || result_ready;
	// Advance the held word unless it makes a result that has nowhere to go.
	assign advance  = valid_s1 && (out_free || !res.valid);
	assign load_out = advance && res.valid;
	assign rx_ready = !valid_s1 || advance;
	// A frame verdict leaves the core this cycle.
	assign frame_end = load_out && (res.kind != KIND_PAYLOAD);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	flr_frame_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.res     (res),
		.status  (status)
	);

	// Result register: hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_out) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			kind_s2    <= res.kind;
			payload_s2 <= res.payload_byte;
			flags_s2   <= res.frame_flags;
			length_s2  <= res.frame_length;
		end
	end

	assign result_valid = valid_s2;
	assign result_kind  = kind_s2;
	assign payload_byte = payload_s2;
	assign frame_flags  = flags_s2;
	assign frame_length = length_s2;

	// A word that makes a result never overwrites one still waiting.
	`FLR_ASSERT_NOW(a_no_overwrite, load_out, out_free, "result overwritten while stalled")
	// A frame verdict always sends the core back to hunting.
	`FLR_ASSERT_NEXT(a_end_hunts, frame_end, status.hunting, "no return to hunting after frame end")
	// Results come only from inside a frame.
	`FLR_ASSERT_NOW(a_no_hunt_result, valid_s1 && status.hunting, !res.valid, "result while hunting")
	// Input back-pressure only with a word held in the input register and a stalled result.
	`FLR_ASSERT_NOW(a_ready_reason, !rx_ready, valid_s1 && valid_s2 && !result_ready, "stray stall")

endmodule

/* hdl/flr_frame_core.sv */
// -----------------------------------------------------------------------------
// Framed link receiver frame core
// Mode state, sync window, header capture, unescape and CRC for one word/step.
// -----------------------------------------------------------------------------
module flr_frame_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	input  flr_pkg::cfg_t    cfg,
	output flr_pkg::result_t res,
	output flr_pkg::status_t status
);
	import flr_pkg::*;

	typedef enum logic [1:0] {
		MODE_HUNT   = 2'd0,
		MODE_HEADER = 2'd1,
		MODE_BODY   = 2'd2
	} mode_t;

	mode_t       mode_q, mode_d;
	logic        esc_q, esc_d;
	logic [31:0] window_q, window_d;
	logic [2:0]  fill_q, fill_d;
	logic [39:0] header_q, header_d;
	logic [16:0] count_q, count_d;
	logic [31:0] crc_q, crc_d;
	logic [31:0] crc_rx_q, crc_rx_d;

	logic        take;
	logic [31:0] crc_upd;
	logic [15:0] hd_flags, hd_len;
	logic [7:0]  hd_check;
	logic [16:0] pos;
	logic [17:0] pos_inc, len_end;

	assign crc_upd = crc_byte(crc_q, rx_byte);
	assign pos     = count_q - 17'(HeaderBytes);
	assign pos_inc = {1'b0, pos} + 18'd1;
	assign len_end = {2'b00, header_q[31:16]} + 18'(CrcBytes);
	assign status.hunting = (mode_q != MODE_HEADER) && (mode_q != MODE_BODY);

	always_comb begin
		mode_d   = mode_q;
		esc_d    = esc_q;
		window_d = window_q;
		fill_d   = fill_q;
		header_d = header_q;
		count_d  = count_q;
		crc_d    = crc_q;
		crc_rx_d = crc_rx_q;
		take     = 1'b0;
		hd_flags = 16'd0;
		hd_len   = 16'd0;
		hd_check = 8'd0;

		res.valid        = 1'b0;
		res.kind         = KIND_PAYLOAD;
		res.payload_byte = 8'd0;
		res.frame_flags  = header_q[15:0];
		res.frame_length = header_q[31:16];

		unique case (mode_q)
			MODE_HEADER, MODE_BODY: begin
				// drop the escape and take the next word literally
				if (esc_q) begin
					esc_d = 1'b0;
					take  = 1'b1;
				end else if (rx_byte == cfg.escape_byte) begin
					esc_d = 1'b1;
				end else begin
					take = 1'b1;
				end

				if (take && mode_q == MODE_HEADER) begin
					for (int i = 0; i < 5; i++) begin
						if (count_q[2:0] == 3'(i)) begin
							header_d[8*i +: 8] = header_q[8*i +: 8] | rx_byte;
						end
					end
					crc_d   = crc_upd;
					count_d = count_q + 17'd1;
					if (count_d == 17'(HeaderBytes)) begin
						hd_flags = header_d[15:0];
						hd_len   = header_d[31:16];
						hd_check = header_d[39:32];
						if (hd_check == (hd_flags[7:0] ^ hd_flags[15:8] ^ hd_len[7:0] ^
								hd_len[15:8]) && hd_len <= cfg.max_payload) begin
							mode_d = MODE_BODY;
						end else begin
							mode_d   = MODE_HUNT;
							window_d = 32'd0;
							fill_d   = 3'd0;
							esc_d    = 1'b0;
							count_d  = 17'd0;
						end
					end
				end else if (take) begin
					count_d = count_q + 17'd1;
					if (pos < {1'b0, header_q[31:16]}) begin
						crc_d            = crc_upd;
						res.valid        = 1'b1;
						res.payload_byte = rx_byte;
					end else begin
						crc_rx_d = {rx_byte, crc_rx_q[31:8]};
						if (pos_inc >= len_end) begin
							res.valid = 1'b1;
							res.kind  = ((crc_q ^ CrcInit) == crc_rx_d) ? KIND_CRC_GOOD
								: KIND_CRC_BAD;
							mode_d   = MODE_HUNT;
							window_d = 32'd0;
							fill_d   = 3'd0;
							esc_d    = 1'b0;
							count_d  = 17'd0;
						end
					end
				end
			end
			default: begin
				// hunting: oldest word lands in the low byte
				window_d = {rx_byte, window_q[31:8]};
				if (fill_q < 3'd4) begin
					fill_d = fill_q + 3'd1;
				end
				if (fill_d >= 3'd4 && window_d == cfg.preamble_word) begin
					mode_d   = MODE_HEADER;
					count_d  = 17'd0;
					esc_d    = 1'b0;
					header_d = 40'd0;
					crc_d    = CrcInit;
					crc_rx_d = 32'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_HUNT;
			esc_q    <= 1'b0;
			window_q <= 32'd0;
			fill_q   <= 3'd0;
			header_q <= 40'd0;
			count_q  <= 17'd0;
			crc_q    <= CrcInit;
			crc_rx_q <= 32'd0;
		end else if (step) begin
			mode_q   <= mode_d;
			esc_q    <= esc_d;
			window_q <= window_d;
			fill_q   <= fill_d;
			header_q <= header_d;
			count_q  <= count_d;
			crc_q    <= crc_d;
			crc_rx_q <= crc_rx_d;
		end
	end

endmodule

/* tb/tb_framed_link_receiver.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Framed link receiver testbench
// Feeds byte streams through the rx channel under random back-pressure and
// compares every result word with an in-bench decoder of the same link format.
// Three zero bytes and a short scripted stream come first, then randomized frames
// (good, corrupted CRC, broken header, noise) under several register settings.
// -----------------------------------------------------------------------------
module tb_framed_link_receiver;
	import flr_pkg::*;

	// Unlisted register index; writes to it must change nothing.
	localparam logic [1:0] RegUnused = 2'd3;

	// Source of a scripted byte: a literal, or one byte of the trailer CRC.
	localparam logic [2:0] SRC_LIT  = 3'd0;
	localparam logic [2:0] SRC_CRC0 = 3'd1;
	localparam logic [2:0] SRC_CRC1 = 3'd2;
	localparam logic [2:0] SRC_CRC2 = 3'd3;
	localparam logic [2:0] SRC_CRC3 = 3'd4;

	localparam int WordsPerPhase = 125;
	localparam int NumPhases     = 6;
	localparam int SettleCycles  = 8;

	typedef enum logic [1:0] {
		RX_HUNT   = 2'd0,
		RX_HEADER = 2'd1,
		RX_BODY   = 2'd2
	} rx_mode_t;

	typedef enum int {
		FR_GOOD,
		FR_BAD_CRC,
		FR_BAD_CHECK,
		FR_TOO_LONG,
		FR_NOISE,
		FR_NEAR_MISS
	} frame_shape_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [15:0] flags;
		logic [15:0] length;
	} frame_out_t;

	typedef struct packed {
		logic [7:0] value;
		logic [2:0] src;
		logic       typed;
		kind_t      kind;
	} script_row_t;

	// Scripted stream, run with sync word D3912A7D, escape 7D, length limit 1.
	localparam int ScriptLen = 37;
	localparam script_row_t Script [0:ScriptLen-1] = '{
		// sync word whose first byte equals the escape: no effect while hunting
		'{8'h7D, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h2A, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h91, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'hD3, SRC_LIT, 1'b0, KIND_PAYLOAD},
		// zero-length frame, flags 7DFF with an escaped escape, good CRC
		'{8'hFF, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h7D, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h7D, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h00, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h00, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h82, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h00, SRC_CRC0, 1'b0, KIND_PAYLOAD},
		'{8'h00, SRC_CRC1, 1'b0, KIND_PAYLOAD},
		'{8'h00, SRC_CRC2, 1'b0, KIND_PAYLOAD},
		'{8'h00, SRC_CRC3, 1'b1, KIND_CRC_GOOD},
		// back to hunting: full sync again
		'{8'h7D, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h2A, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h91, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'hD3, SRC_LIT, 1'b0, KIND_PAYLOAD},
		// one-byte payload FF, zero trailer: CRC bad
		'{8'h00, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h00, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h01, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h00, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h01, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'hFF, SRC_LIT, 1'b1, KIND_PAYLOAD},
		'{8'h00, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h00, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h00, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h00, SRC_LIT, 1'b1, KIND_CRC_BAD},
		// sync, then a header whose length 2 exceeds the limit: dropped
		'{8'h7D, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h2A, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h91, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'hD3, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'hFF, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'hFF, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h02, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h00, SRC_LIT, 1'b0, KIND_PAYLOAD},
		'{8'h02, SRC_LIT, 1'b0, KIND_PAYLOAD}
	};

	logic        clk;
	logic        arst_n;
	logic        rx_valid;
	logic        rx_ready;
	logic [7:0]  rx_byte;
	logic        result_valid;
	logic        result_ready;
	logic [1:0]  result_kind;
	logic [7:0]  payload_byte;
	logic [15:0] frame_flags;
	logic [15:0] frame_length;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	framed_link_receiver u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_ready     (rx_ready),
		.rx_byte      (rx_byte),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_kind  (result_kind),
		.payload_byte (payload_byte),
		.frame_flags  (frame_flags),
		.frame_length (frame_length),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Decoder copy of the registers and the receive state.
	logic [31:0] cfg_sync;
	logic [7:0]  cfg_esc;
	logic [15:0] cfg_max;
	rx_mode_t    p_mode;
	logic        p_esc_armed;
	logic [31:0] p_window;
	int          p_fill;
	logic [39:0] p_hdr;
	int          p_count;
	logic [31:0] p_crc;
	logic [31:0] p_crc_rx;

	frame_out_t decoded_q[$];
	bit         no_idle;
	int         err_count;
	int         words_sent;
	int         seen_payload;
	int         seen_good;
	int         seen_bad;
	bit         last_hit;
	frame_out_t last_out;

	// Reflected CRC-32, one byte, LSB first.
	function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
		end
		return c;
	endfunction

	// Drop back to preamble hunting with an empty window.
	function automatic void decoder_rehunt();
		p_mode      = RX_HUNT;
		p_window    = '0;
		p_fill      = 0;
		p_esc_armed = 1'b0;
		p_count     = 0;
	endfunction

	// Advance the decoder by one received byte; returns 1 when a result word is due.
	function automatic bit frame_decode(input logic [7:0] b, output frame_out_t r);
		logic [15:0] f;
		logic [15:0] l;
		int          pos;
		r = '0;
		if (p_mode != RX_HEADER && p_mode != RX_BODY) begin
			// hunting (also the unused mode code): slide the window, escape ignored
			p_window = {b, p_window[31:8]};
			if (p_fill < 4) p_fill++;
			if (p_fill >= 4 && p_window == cfg_sync) begin
				p_mode      = RX_HEADER;
				p_count     = 0;
				p_esc_armed = 1'b0;
				p_hdr       = '0;
				p_crc       = CrcInit;
				p_crc_rx    = '0;
			end
			return 1'b0;
		end
		if (p_esc_armed) begin
			p_esc_armed = 1'b0;
		end else if (b == cfg_esc) begin
			p_esc_armed = 1'b1;
			return 1'b0;
		end
		if (p_mode == RX_HEADER) begin
			p_hdr = p_hdr | ({32'd0, b} << (8 * (p_count % HeaderBytes)));
			p_crc = crc32_update(p_crc, b);
			p_count++;
			if (p_count < HeaderBytes) return 1'b0;
			f = p_hdr[15:0];
			l = p_hdr[31:16];
			if (p_hdr[39:32] == (f[7:0] ^ f[15:8] ^ l[7:0] ^ l[15:8]) && l <= cfg_max) begin
				p_mode = RX_BODY;
			end else begin
				decoder_rehunt();
			end
			return 1'b0;
		end
		l = p_hdr[31:16];
		pos = p_count - HeaderBytes;
		p_count++;
		r.flags  = p_hdr[15:0];
		r.length = l;
		if (pos < l) begin
			p_crc  = crc32_update(p_crc, b);
			r.kind = KIND_PAYLOAD;
			r.data = b;
			return 1'b1;
		end
		p_crc_rx = {b, p_crc_rx[31:8]};
		if (pos + 1 < l + CrcBytes) return 1'b0;
		r.kind = (~p_crc == p_crc_rx) ? KIND_CRC_GOOD : KIND_CRC_BAD;
		decoder_rehunt();
		return 1'b1;
	endfunction

	// Offer one word, hold it until accepted, then run it through the decoder.
	task automatic send_byte(input logic [7:0] b);
		while (!no_idle && $urandom_range(99) < 35) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!rx_ready) @(posedge clk);
		words_sent++;
		last_hit = frame_decode(b, last_out);
		if (last_hit) decoded_q.push_back(last_out);
	endtask

	// Body/header byte: stuff an escape where needed, and now and then where not.
	task automatic send_stuffed(input logic [7:0] b);
		if (b == cfg_esc || $urandom_range(99) < 3) send_byte(cfg_esc);
		send_byte(b);
	endtask

	// Stop offering words, let every result drain, then allow the pipe to settle.
	task automatic wait_idle();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Write all registers back to back, plus a junk write to the unused index.
	task automatic apply_config(input logic [31:0] sync_w, input logic [7:0] esc,
			input logic [15:0] maxlen);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PREAMBLE;
		cfg_data  <= sync_w;
		@(posedge clk);
		cfg_sync = sync_w;
		cfg_index <= REG_ESCAPE;
		cfg_data  <= {24'($urandom_range(16777215)), esc};
		@(posedge clk);
		cfg_esc = esc;
		cfg_index <= REG_MAX_LEN;
		cfg_data  <= {16'($urandom_range(65535)), maxlen};
		@(posedge clk);
		cfg_max = maxlen;
		cfg_index <= RegUnused;
		cfg_data  <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_length();
		int cap;
		cap = ($urandom_range(99) < 85) ? 12 : 200;
		if (cap > cfg_max) cap = cfg_max;
		return 16'($urandom_range(cap));
	endfunction

	// One random frame (or broken fragment) of the given shape.
	task automatic send_frame(input frame_shape_t shape, input int force_len);
		frame_shape_t sh;
		logic [15:0]  f;
		logic [15:0]  l;
		logic [7:0]   hdr [5];
		logic [31:0]  c;
		logic [7:0]   b;
		int           r;
		sh = shape;
		// flush whatever a previous fragment left open, so the preamble lands in a hunt
		while (p_mode == RX_HEADER || p_mode == RX_BODY) send_byte(8'($urandom));
		if (sh == FR_NOISE) begin
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
			return;
		end
		for (int k = 0; k < 4; k++) begin
			b = cfg_sync[8*k +: 8];
			if (sh == FR_NEAR_MISS && k == 3) b = b ^ 8'($urandom_range(1, 255));
			send_byte(b);
		end
		if (sh == FR_NEAR_MISS) return;
		r = $urandom_range(99);
		f = (r < 10) ? 16'h0000 : (r < 20) ? 16'hFFFF : 16'($urandom);
		if (sh == FR_TOO_LONG && cfg_max == 16'hFFFF) sh = FR_BAD_CHECK;
		if (sh == FR_TOO_LONG) begin
			l = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(cfg_max + 1, 65535));
		end else if (force_len >= 0) begin
			l = 16'(force_len);
		end else begin
			l = pick_length();
		end
		hdr[0] = f[7:0];
		hdr[1] = f[15:8];
		hdr[2] = l[7:0];
		hdr[3] = l[15:8];
		hdr[4] = f[7:0] ^ f[15:8] ^ l[7:0] ^ l[15:8];
		if (sh == FR_BAD_CHECK) hdr[4] = hdr[4] ^ 8'($urandom_range(1, 255));
		c = CrcInit;
		for (int k = 0; k < 5; k++) begin
			c = crc32_update(c, hdr[k]);
			send_stuffed(hdr[k]);
		end
		if (sh == FR_BAD_CHECK || sh == FR_TOO_LONG) return;
		for (int i = 0; i < l; i++) begin
			b = 8'($urandom);
			c = crc32_update(c, b);
			send_stuffed(b);
		end
		c = ~c;
		if (sh == FR_BAD_CRC) c = c ^ (32'd1 << $urandom_range(31));
		for (int k = 0; k < 4; k++) send_stuffed(c[8*k +: 8]);
	endtask

	// Result side: random stalls, none while no_idle is set.
	always @(posedge clk) begin
		result_ready <= no_idle || ($urandom_range(99) >= 35);
	end

	// Check every accepted result word against the oldest decoded expectation.
	always @(posedge clk) begin
		frame_out_t exp_w;
		if (arst_n && result_valid && result_ready) begin
			if (decoded_q.size() == 0) begin
				$error("result word with nothing expected: kind %0d byte %h", result_kind,
					payload_byte);
				err_count++;
			end else begin
				exp_w = decoded_q.pop_front();
				if (result_kind != exp_w.kind) begin
					$error("result_kind mismatch: expected %0d, actual %0d", exp_w.kind,
						result_kind);
					err_count++;
				end
				if (payload_byte != exp_w.data) begin
					$error("payload_byte mismatch: expected %h, actual %h", exp_w.data,
						payload_byte);
					err_count++;
				end
				if (frame_flags != exp_w.flags) begin
					$error("frame_flags mismatch: expected %h, actual %h", exp_w.flags,
						frame_flags);
					err_count++;
				end
				if (frame_length != exp_w.length) begin
					$error("frame_length mismatch: expected %0d, actual %0d", exp_w.length,
						frame_length);
					err_count++;
				end
				case (exp_w.kind)
					KIND_PAYLOAD:  seen_payload++;
					KIND_CRC_GOOD: seen_good++;
					default:       seen_bad++;
				endcase
			end
		end
	end

	// Main sequence: reset, scripted stream, then randomized phases.
	initial begin
		script_row_t  row;
		logic [7:0]   b;
		int           target;
		int           r;
		bit           big_done;
		frame_shape_t sh;
		logic [31:0]  sync_w;
		logic [7:0]   esc;
		logic [15:0]  maxlen;

		arst_n    <= 1'b0;
		rx_valid  <= 1'b0;
		rx_byte   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_PREAMBLE;
		cfg_data  <= '0;
		no_idle      = 1'b0;
		err_count    = 0;
		words_sent   = 0;
		seen_payload = 0;
		seen_good    = 0;
		seen_bad     = 0;
		big_done     = 1'b0;
		// decoder mirrors the reset state
		cfg_sync = '0;
		cfg_esc  = '0;
		cfg_max  = MaxPayloadReset;
		decoder_rehunt();
		p_hdr    = '0;
		p_crc    = CrcInit;
		p_crc_rx = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Three zero bytes at reset defaults: window not full, so no sync on zero.
		repeat (3) send_byte(8'h00);
		wait_idle();

		// Scripted stream.
		apply_config(32'hD391_2A7D, 8'h7D, 16'd1);
		for (int i = 0; i < ScriptLen; i++) begin
			row = Script[i];
			if (row.src == SRC_LIT) begin
				b = row.value;
			end else begin
				b = 8'((~p_crc) >> (8 * (row.src - SRC_CRC0)));
				if (b == cfg_esc) send_byte(cfg_esc);
			end
			send_byte(b);
			if (row.typed && (!last_hit || last_out.kind != row.kind ||
					(row.kind == KIND_PAYLOAD && last_out.data != row.value))) begin
				$error("scripted word %0d: expected kind %0d, decoder gave %0d (hit %0d)", i,
					row.kind, last_out.kind, last_hit);
				err_count++;
			end
		end
		wait_idle();

		// Randomized phases; each ends at the first frame boundary once its word count is met.
		for (int ph = 0; ph < NumPhases; ph++) begin
			sync_w = $urandom;
			esc    = 8'($urandom);
			case (ph)
				0: begin
					sync_w = 32'h0000_0000;
					esc    = 8'h00;
					maxlen = 16'h0000;
				end
				1: begin
					sync_w = 32'hFFFF_FFFF;
					esc    = 8'hFF;
					maxlen = 16'hFFFF;
				end
				2: maxlen = MaxPayloadReset;
				3: maxlen = 16'($urandom_range(40));
				4: maxlen = 16'($urandom);
				default: begin
					// escape shares a value with a sync byte
					esc    = sync_w[8*$urandom_range(3) +: 8];
					maxlen = 16'($urandom_range(20));
				end
			endcase
			apply_config(sync_w, esc, maxlen);
			no_idle = (ph == 3);
			target = words_sent + WordsPerPhase;
			while (words_sent < target) begin
				r = $urandom_range(99);
				sh = (r < 55) ? FR_GOOD : (r < 70) ? FR_BAD_CRC : (r < 78) ? FR_BAD_CHECK :
					(r < 85) ? FR_TOO_LONG : (r < 93) ? FR_NOISE : FR_NEAR_MISS;
				if (ph == 1 && !big_done) begin
					send_frame(FR_GOOD, MaxPayloadReset);
					big_done = 1'b1;
				end else begin
					send_frame(sh, -1);
				end
			end
			wait_idle();
		end
		no_idle = 1'b0;

		// Final drain; the watchdog covers a result that never shows.
		rx_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		if (decoded_q.size() != 0) begin
			$error("%0d expected result words never arrived", decoded_q.size());
			err_count++;
		end

		$display("Run covered %0d words over %0d register settings plus a scripted stream.",
			words_sent, NumPhases);
		$display("Checked %0d payload bytes, %0d good and %0d bad frame ends; %0d errors.",
			seen_payload, seen_good, seen_bad, err_count);
		if (err_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("Timeout: stimulus or results stuck");
		$display("Verification failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/flr_pkg.sv
hdl/flr_frame_core.sv
hdl/framed_link_receiver.sv
tb/tb_framed_link_receiver.sv
